FILE: sv/dis_pkg.sv
// ----------------------------------------------------------------------------
// Disjoint interval set package
// Shared constants, codes and control types for the disjoint interval set.
// ----------------------------------------------------------------------------
package dis_pkg;

  localparam int MAX_INTERVALS = 32;
  localparam int VALUE_BITS    = 16;
  localparam int COUNT_W       = $clog2(MAX_INTERVALS + 1);
  localparam int IDX_W         = $clog2(MAX_INTERVALS);

  typedef enum logic {
    OP_ADD  = 1'b0,
    OP_LIST = 1'b1
  } opcode_t;

  typedef enum logic [2:0] {
    ST_COVERED   = 3'd0,
    ST_NEW       = 3'd1,
    ST_END_EXT   = 3'd2,
    ST_START_EXT = 3'd3,
    ST_JOINED    = 3'd4,
    ST_FULL      = 3'd5,
    ST_ENTRY     = 3'd6,
    ST_EMPTY     = 3'd7
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_ADD,
    S_LIST
  } ctrl_state_t;

  typedef struct packed {
    logic capture;
    logic add_exec;
    logic list_emit;
    logic list_last;
    logic list_empty;
  } dis_cmd_t;

  typedef struct packed {
    logic               out_free;
    logic [COUNT_W-1:0] count;
  } dis_stat_t;

endpackage

FILE: sv/dis_if.sv
// ----------------------------------------------------------------------------
// Disjoint interval set channels
// Request and response channels with valid/ready handshakes.
// ----------------------------------------------------------------------------
interface dis_req_if;
  logic                           valid;
  logic                           ready;
  dis_pkg::opcode_t               opcode;
  logic [dis_pkg::VALUE_BITS-1:0] value;

  modport source (output valid, output opcode, output value, input ready);
  modport sink   (input valid, input opcode, input value, output ready);
endinterface

interface dis_rsp_if;
  logic                           valid;
  logic                           ready;
  dis_pkg::status_t               status;
  logic [dis_pkg::VALUE_BITS-1:0] interval_start;
  logic [dis_pkg::VALUE_BITS-1:0] interval_end;
  logic [dis_pkg::COUNT_W-1:0]    interval_count;
  logic                           last_item;

  modport source (output valid, output status, output interval_start, output interval_end,
                  output interval_count, output last_item, input ready);
  modport sink   (input valid, input status, input interval_start, input interval_end,
                  input interval_count, input last_item, output ready);
endinterface

FILE: sv/dis_ctrl.sv
// ----------------------------------------------------------------------------
// Disjoint interval set controller
// Sequences request capture, the add update and the listing walk.
// ----------------------------------------------------------------------------
module dis_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  input  dis_pkg::opcode_t  req_opcode,
  output logic              req_ready,
  input  dis_pkg::dis_stat_t stat,
  output dis_pkg::dis_cmd_t cmd
);
  import dis_pkg::*;

  ctrl_state_t      state;
  ctrl_state_t      state_next;
  logic [IDX_W-1:0] idx;
  logic [IDX_W-1:0] idx_next;
  logic             last;

  assign last = (COUNT_W'(idx) + COUNT_W'(1)) == stat.count;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      idx   <= '0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          state_next = (req_opcode == OP_ADD) ? S_ADD : S_LIST;
        end
      end
      S_ADD: begin
        if (stat.out_free) begin
          state_next = S_IDLE;
        end
      end
      S_LIST: begin
        if (stat.out_free && ((stat.count == '0) || last)) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    req_ready = 1'b0;
    cmd       = '0;
    idx_next  = idx;
    case (state)
      S_IDLE: begin
        req_ready   = 1'b1;
        cmd.capture = req_valid;
      end
      S_ADD: begin
        cmd.add_exec = stat.out_free;
      end
      S_LIST: begin
        if (stat.out_free) begin
          if (stat.count == '0) begin
            cmd.list_empty = 1'b1;
          end else begin
            cmd.list_emit = 1'b1;
            cmd.list_last = last;
            idx_next      = last ? '0 : idx + IDX_W'(1);
          end
        end
      end
      default: begin
        idx_next = '0;
      end
    endcase
  end

endmodule

FILE: sv/dis_datapath.sv
// ----------------------------------------------------------------------------
// Disjoint interval set datapath
// Interval cells with parallel compare, insert, extend, merge and rotate, and the
// response register.
// ----------------------------------------------------------------------------
module dis_datapath (
  input  logic                           clk,
  input  logic                           rst,
  input  dis_pkg::dis_cmd_t              cmd,
  input  logic [dis_pkg::VALUE_BITS-1:0] req_value,
  output dis_pkg::dis_stat_t             stat,
  dis_rsp_if.source                      rsp
);
  import dis_pkg::*;

  logic [VALUE_BITS-1:0] start_cell [MAX_INTERVALS];
  logic [VALUE_BITS-1:0] end_cell   [MAX_INTERVALS];
  logic [COUNT_W-1:0]    count;
  logic [VALUE_BITS-1:0] v;
  logic [MAX_INTERVALS-1:0] lt;
  logic [MAX_INTERVALS:0]   lt_sh;
  logic [MAX_INTERVALS:0]   peq;
  logic [MAX_INTERVALS-1:0] p_hit;

  logic [VALUE_BITS-1:0] start_p;
  logic [VALUE_BITS-1:0] end_p;
  logic [VALUE_BITS-1:0] start_pm1;
  logic [VALUE_BITS-1:0] end_pm1;
  logic                  has_p;
  logic                  has_prev;
  logic                  left_touch;
  logic                  right_touch;

  status_t               kind;
  logic [VALUE_BITS-1:0] res_start;
  logic [VALUE_BITS-1:0] res_end;
  logic [COUNT_W-1:0]    count_after;

  logic                  out_valid;
  status_t               out_status;
  logic [VALUE_BITS-1:0] out_start;
  logic [VALUE_BITS-1:0] out_end;
  logic [COUNT_W-1:0]    out_count;
  logic                  out_last;

  assign stat.out_free = !out_valid || rsp.ready;
  assign stat.count    = count;

  // The insertion point is the first held interval whose end is not below v.
  assign lt_sh = {lt, 1'b1};

  always_comb begin
    for (int k = 0; k < MAX_INTERVALS; k++) begin
      peq[k]   = (COUNT_W'(k) <= count) && !lt[k] && lt_sh[k];
      p_hit[k] = peq[k] && (COUNT_W'(k) < count);
    end
    peq[MAX_INTERVALS] = lt_sh[MAX_INTERVALS];
  end

  always_comb begin
    start_p   = '0;
    end_p     = '0;
    start_pm1 = '0;
    end_pm1   = '0;
    for (int k = 0; k < MAX_INTERVALS; k++) begin
      start_p   = start_p   | ({VALUE_BITS{p_hit[k]}}  & start_cell[k]);
      end_p     = end_p     | ({VALUE_BITS{p_hit[k]}}  & end_cell[k]);
      start_pm1 = start_pm1 | ({VALUE_BITS{peq[k+1]}}  & start_cell[k]);
      end_pm1   = end_pm1   | ({VALUE_BITS{peq[k+1]}}  & end_cell[k]);
    end
  end

  assign has_p       = |p_hit;
  assign has_prev    = !peq[0];
  assign left_touch  = has_prev && (({1'b0, end_pm1} + (VALUE_BITS+1)'(1)) == {1'b0, v});
  assign right_touch = has_p && ({1'b0, start_p} == ({1'b0, v} + (VALUE_BITS+1)'(1)));

  always_comb begin
    kind        = ST_NEW;
    res_start   = v;
    res_end     = v;
    count_after = count;
    if (has_p && (start_p <= v)) begin
      kind      = ST_COVERED;
      res_start = start_p;
      res_end   = end_p;
    end else if (left_touch && right_touch) begin
      kind        = ST_JOINED;
      res_start   = start_pm1;
      res_end     = end_p;
      count_after = count - COUNT_W'(1);
    end else if (left_touch) begin
      kind      = ST_END_EXT;
      res_start = start_pm1;
    end else if (right_touch) begin
      kind    = ST_START_EXT;
      res_end = end_p;
    end else if (count == COUNT_W'(MAX_INTERVALS)) begin
      kind      = ST_FULL;
      res_start = '0;
      res_end   = '0;
    end else begin
      count_after = count + COUNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      v <= req_value;
      for (int k = 0; k < MAX_INTERVALS; k++) begin
        lt[k] <= (COUNT_W'(k) < count) && (end_cell[k] < req_value);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.add_exec) begin
      count <= count_after;
    end
  end

  genvar g;
  generate
    for (g = 0; g < MAX_INTERVALS; g++) begin : g_cell
      logic [VALUE_BITS-1:0] prev_start;
      logic [VALUE_BITS-1:0] prev_end;
      logic [VALUE_BITS-1:0] succ_start;
      logic [VALUE_BITS-1:0] succ_end;
      logic                  shift_in;
      logic                  shift_out;
      logic                  wrap;
      logic                  keep_succ;

      if (g == 0) begin : g_first
        assign prev_start = start_cell[g];
        assign prev_end   = end_cell[g];
        assign shift_in   = 1'b0;
      end else begin : g_rest
        assign prev_start = start_cell[g-1];
        assign prev_end   = end_cell[g-1];
        assign shift_in   = (COUNT_W'(g) <= count) && !lt[g-1];
      end

      if (g == MAX_INTERVALS - 1) begin : g_last
        assign succ_start = start_cell[g];
        assign succ_end   = end_cell[g];
        assign keep_succ  = 1'b0;
      end else begin : g_inner
        assign succ_start = start_cell[g+1];
        assign succ_end   = end_cell[g+1];
        assign keep_succ  = (COUNT_W'(g + 1) < count);
      end

      assign shift_out = keep_succ && !lt[g];
      assign wrap      = (COUNT_W'(g) + COUNT_W'(1)) == count;

      always_ff @(posedge clk) begin
        if (cmd.add_exec) begin
          case (kind)
            ST_NEW: begin
              if (peq[g]) begin
                start_cell[g] <= v;
                end_cell[g]   <= v;
              end else if (shift_in) begin
                start_cell[g] <= prev_start;
                end_cell[g]   <= prev_end;
              end
            end
            ST_JOINED: begin
              if (peq[g+1]) begin
                end_cell[g] <= end_p;
              end else if (shift_out) begin
                start_cell[g] <= succ_start;
                end_cell[g]   <= succ_end;
              end
            end
            ST_END_EXT: begin
              if (peq[g+1]) begin
                end_cell[g] <= v;
              end
            end
            ST_START_EXT: begin
              if (p_hit[g]) begin
                start_cell[g] <= v;
              end
            end
            default: begin
            end
          endcase
        end else if (cmd.list_emit) begin
          if (wrap) begin
            start_cell[g] <= start_cell[0];
            end_cell[g]   <= end_cell[0];
          end else if (keep_succ) begin
            start_cell[g] <= succ_start;
            end_cell[g]   <= succ_end;
          end
        end
      end
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.add_exec || cmd.list_emit || cmd.list_empty) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.add_exec) begin
      out_status <= kind;
      out_start  <= res_start;
      out_end    <= res_end;
      out_count  <= count_after;
      out_last   <= 1'b1;
    end else if (cmd.list_emit) begin
      out_status <= ST_ENTRY;
      out_start  <= start_cell[0];
      out_end    <= end_cell[0];
      out_count  <= count;
      out_last   <= cmd.list_last;
    end else if (cmd.list_empty) begin
      out_status <= ST_EMPTY;
      out_start  <= '0;
      out_end    <= '0;
      out_count  <= count;
      out_last   <= 1'b1;
    end
  end

  assign rsp.valid          = out_valid;
  assign rsp.status         = out_status;
  assign rsp.interval_start = out_start;
  assign rsp.interval_end   = out_end;
  assign rsp.interval_count = out_count;
  assign rsp.last_item      = out_last;

endmodule

FILE: sv/disjoint_interval_set.sv
// ----------------------------------------------------------------------------
// Disjoint interval set
// Sorted table of disjoint closed intervals with add and listing requests.
// ----------------------------------------------------------------------------
// Channel  Role  Carries
// req      sink  opcode, value
// rsp      src   status, interval_start, interval_end, interval_count, last_item
//
// An add is accepted while its value is compared against every held interval
// in parallel; the cells then insert, extend or merge once the response
// register is free. A listing is accepted and then emits the held intervals
// in order as the response register frees, since the cells rotate through a
// single read port at the head; an empty listing gives a single result.
// Reset clears the interval count and the controller; the cells need no clearing.
// A stalled response holds the block before its next result is loaded.
// ----------------------------------------------------------------------------
module disjoint_interval_set (
  input logic clk,
  input logic rst,
  dis_req_if.sink   req,
  dis_rsp_if.source rsp
);
  import dis_pkg::*;

  dis_cmd_t  cmd;
  dis_stat_t stat;

  dis_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req.valid),
    .req_opcode (req.opcode),
    .req_ready  (req.ready),
    .stat       (stat),
    .cmd        (cmd)
  );

  dis_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .req_value (req.value),
    .stat      (stat),
    .rsp       (rsp)
  );

endmodule

FILE: test/disjoint_interval_set_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Disjoint interval set testbench
// Drives add and listing requests through the request channel with random
// gaps, stalls the response channel at random, and checks every response
// transaction against a behavioural copy of the interval table kept here.
// ----------------------------------------------------------------------------
module disjoint_interval_set_tb;
  import dis_pkg::*;

  typedef struct packed {
    opcode_t               op;
    logic [VALUE_BITS-1:0] value;
  } request_t;

  typedef struct packed {
    status_t               status;
    logic [VALUE_BITS-1:0] lo;
    logic [VALUE_BITS-1:0] hi;
    logic [COUNT_W-1:0]    count;
    logic                  last_item;
  } response_t;

  logic clk;
  logic rst;

  dis_req_if req_ch ();
  dis_rsp_if rsp_ch ();

  disjoint_interval_set u_dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  request_t              requests_todo[$];
  response_t             results_due[$];
  logic [VALUE_BITS-1:0] set_lo[MAX_INTERVALS];
  logic [VALUE_BITS-1:0] set_hi[MAX_INTERVALS];
  int                    set_count;

  int  n_errors;
  int  n_requests;
  int  n_listings;
  int  n_results;
  int  n_joins;
  int  n_dropped;
  bit  req_fire;
  bit  rsp_fire;
  int  req_gap;
  int  rsp_hold;
  bit  req_quiet;
  bit  rsp_quiet;
  int  req_draws;
  int  rsp_draws;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    rst               = 1'b1;
    req_ch.valid      = 1'b0;
    req_ch.opcode     = OP_ADD;
    req_ch.value      = '0;
    rsp_ch.ready      = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
  end

  initial begin
    #1_000_000;
    $display("Timed out with %0d results outstanding.", results_due.size());
    $display("DONE: errors detected");
    $finish;
  end

  task automatic push_result(input status_t st, input logic [VALUE_BITS-1:0] lo,
                             input logic [VALUE_BITS-1:0] hi, input logic last_item);
    response_t r;
    r.status    = st;
    r.lo        = lo;
    r.hi        = hi;
    r.count     = set_count[COUNT_W-1:0];
    r.last_item = last_item;
    results_due = {results_due, r};
  endtask

  task automatic apply_add(input logic [VALUE_BITS-1:0] v);
    int p;
    int i;
    bit lt;
    bit rt;
    p = 0;
    while (p < set_count && set_hi[p] < v) p++;
    if (p < set_count && set_lo[p] <= v) begin
      push_result(ST_COVERED, set_lo[p], set_hi[p], 1'b1);
    end else begin
      lt = 1'b0;
      rt = 1'b0;
      if (p > 0) lt = (int'(set_hi[p-1]) + 1 == int'(v));
      if (p < set_count) rt = (int'(set_lo[p]) == int'(v) + 1);
      if (lt && rt) begin
        set_hi[p-1] = set_hi[p];
        for (i = p; i + 1 < set_count; i++) begin
          set_lo[i] = set_lo[i+1];
          set_hi[i] = set_hi[i+1];
        end
        set_count--;
        n_joins++;
        push_result(ST_JOINED, set_lo[p-1], set_hi[p-1], 1'b1);
      end else if (lt) begin
        set_hi[p-1] = v;
        push_result(ST_END_EXT, set_lo[p-1], v, 1'b1);
      end else if (rt) begin
        set_lo[p] = v;
        push_result(ST_START_EXT, v, set_hi[p], 1'b1);
      end else if (set_count >= MAX_INTERVALS) begin
        n_dropped++;
        push_result(ST_FULL, '0, '0, 1'b1);
      end else begin
        for (i = set_count; i > p; i--) begin
          set_lo[i] = set_lo[i-1];
          set_hi[i] = set_hi[i-1];
        end
        set_lo[p] = v;
        set_hi[p] = v;
        set_count++;
        push_result(ST_NEW, v, v, 1'b1);
      end
    end
  endtask

  task automatic apply_request(input request_t rq);
    int i;
    n_requests++;
    if (rq.op == OP_LIST) begin
      n_listings++;
      if (set_count == 0) begin
        push_result(ST_EMPTY, '0, '0, 1'b1);
      end else begin
        for (i = 0; i < set_count; i++)
          push_result(ST_ENTRY, set_lo[i], set_hi[i], i + 1 == set_count);
      end
    end else begin
      apply_add(rq.value);
    end
  endtask

  function automatic string fmt_result(input response_t r);
    return $sformatf("status %0d start %0d end %0d count %0d last %0b",
                     r.status, r.lo, r.hi, r.count, r.last_item);
  endfunction

  // Acceptance on both channels is decided here, at the rising edge.
  always @(posedge clk) begin
    request_t  rq;
    response_t got;
    response_t want;
    if (rst) begin
      req_fire <= 1'b0;
      rsp_fire <= 1'b0;
    end else begin
      req_fire <= req_ch.valid && req_ch.ready;
      rsp_fire <= rsp_ch.valid && rsp_ch.ready;
      if (req_ch.valid && req_ch.ready) begin
        rq.op    = req_ch.opcode;
        rq.value = req_ch.value;
        apply_request(rq);
      end
      if (rsp_ch.valid && rsp_ch.ready) begin
        got.status    = rsp_ch.status;
        got.lo        = rsp_ch.interval_start;
        got.hi        = rsp_ch.interval_end;
        got.count     = rsp_ch.interval_count;
        got.last_item = rsp_ch.last_item;
        n_results++;
        if (results_due.size() == 0) begin
          n_errors++;
          $display("%0t: unexpected transaction, got %s", $time, fmt_result(got));
        end else begin
          want = results_due.pop_front();
          if (got !== want) begin
            n_errors++;
            $display("%0t: expected %s, got %s", $time, fmt_result(want), fmt_result(got));
          end
        end
      end
    end
  end

  always @(negedge clk) begin
    request_t rq;
    if (rst) begin
      req_ch.valid <= 1'b0;
      req_gap   = 0;
      req_quiet = 1'b0;
      req_draws = 0;
    end else if (!req_ch.valid || req_fire) begin
      if (req_fire) begin
        req_draws++;
        if (req_draws % 40 == 0) req_quiet = ($urandom_range(0, 2) == 0);
        req_gap = req_quiet ? 0 : $urandom_range(0, 4);
      end
      if (req_gap > 0) begin
        req_gap--;
        req_ch.valid <= 1'b0;
      end else if (requests_todo.size() != 0) begin
        rq = requests_todo.pop_front();
        req_ch.opcode <= rq.op;
        req_ch.value  <= rq.value;
        req_ch.valid  <= 1'b1;
      end else begin
        req_ch.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
      rsp_hold  = 0;
      rsp_quiet = 1'b0;
      rsp_draws = 0;
    end else begin
      if (rsp_fire) begin
        rsp_draws++;
        if (rsp_draws % 50 == 0) rsp_quiet = ($urandom_range(0, 2) == 0);
        rsp_hold = rsp_quiet ? 0 : $urandom_range(0, 4);
      end
      if (rsp_hold > 0) begin
        rsp_hold--;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  task automatic queue_add(input logic [VALUE_BITS-1:0] v);
    request_t rq;
    rq.op    = OP_ADD;
    rq.value = v;
    requests_todo = {requests_todo, rq};
  endtask

  task automatic queue_list();
    request_t rq;
    rq.op    = OP_LIST;
    rq.value = VALUE_BITS'($urandom);
    requests_todo = {requests_todo, rq};
  endtask

  initial begin
    int k;
    int n_random;
    int base;
    int w;
    int len;
    int sel;
    n_errors   = 0;
    n_requests = 0;
    n_listings = 0;
    n_results  = 0;
    n_joins    = 0;
    n_dropped  = 0;
    set_count  = 0;

    // Edges of the value range, each way of touching a neighbour, and an empty listing.
    queue_list();
    queue_add(16'd0);
    queue_add(16'hFFFF);
    queue_add(16'hFFFE);
    queue_add(16'd1);
    queue_add(16'd3);
    queue_add(16'd2);
    queue_add(16'd2);
    queue_add(16'd0);
    queue_add(16'hFFFF);
    queue_add(16'h5555);
    queue_add(16'hAAAA);
    queue_add(16'd100);
    queue_add(16'd102);
    queue_add(16'd101);
    queue_list();

    // Fill the table past its capacity, then close the gaps again.
    for (k = 0; k < 36; k++) queue_add(16'(40000 + 3 * k));
    queue_list();
    for (k = 0; k < 36; k++) queue_add(16'(40001 + 3 * k));
    queue_list();
    for (k = 0; k < 36; k++) queue_add(16'(40002 + 3 * k));
    queue_list();

    // Random bursts within narrow windows, so that values touch and bridge.
    n_random = 0;
    while (n_random < 370) begin
      w   = $urandom_range(4, 48);
      sel = $urandom_range(0, 9);
      if (sel == 0) base = 0;
      else if (sel == 1) base = 65536 - w;
      else base = $urandom_range(0, 65536 - w);
      len = $urandom_range(w, 2 * w);
      for (k = 0; k < len; k++) begin
        sel = $urandom_range(0, 99);
        if (sel < 8) queue_list();
        else if (sel < 11) queue_add(VALUE_BITS'($urandom));
        else queue_add(16'(base + $urandom_range(0, w - 1)));
      end
      n_random += len;
    end
    queue_list();

    while (requests_todo.size() != 0 || req_ch.valid) @(posedge clk);
    while (results_due.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    $display("Sent %0d requests including %0d listings; checked %0d response transactions.",
             n_requests, n_listings, n_results);
    $display("%0d adds merged two intervals and %0d were dropped on a full table.",
             n_joins, n_dropped);
    if (n_errors == 0 && results_due.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

FILE: disjoint_interval_set.f
sv/dis_pkg.sv
sv/dis_if.sv
sv/dis_ctrl.sv
sv/dis_datapath.sv
sv/disjoint_interval_set.sv
test/disjoint_interval_set_tb.sv
